>>> rtl/core/icaf_pkg.sv
// Package for the IMU complementary angle filter.
// Holds constants, register codes and the CORDIC arctangent table; no dependencies.
package icaf_pkg;

  localparam int unsigned AtanIterations = 16;
  localparam int unsigned AtanTableSize  = 24;
  localparam int unsigned IterW          = 5;

  localparam logic signed [31:0] RatioQ16 = 32'sd3756840;
  localparam logic signed [39:0] PiQ24    = 40'sd52707179;

  typedef enum logic [2:0] {
    CfgGyroSens    = 3'd0,
    CfgSamplePer   = 3'd1,
    CfgGyroWeight  = 3'd2,
    CfgAccelWeight = 3'd3,
    CfgMagLow      = 3'd4,
    CfgMagHigh     = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StInteg,
    StAtan,
    StBlend,
    StOut
  } state_e;

  function automatic logic signed [39:0] atan_tab(input logic [IterW-1:0] i);
    logic signed [39:0] r;
    case (i)
      5'd0:  r = 40'sd13176795;
      5'd1:  r = 40'sd7778716;
      5'd2:  r = 40'sd4110060;
      5'd3:  r = 40'sd2086331;
      5'd4:  r = 40'sd1047214;
      5'd5:  r = 40'sd524117;
      5'd6:  r = 40'sd262123;
      5'd7:  r = 40'sd131069;
      5'd8:  r = 40'sd65536;
      5'd9:  r = 40'sd32768;
      5'd10: r = 40'sd16384;
      5'd11: r = 40'sd8192;
      5'd12: r = 40'sd4096;
      5'd13: r = 40'sd2048;
      5'd14: r = 40'sd1024;
      5'd15: r = 40'sd512;
      5'd16: r = 40'sd256;
      5'd17: r = 40'sd128;
      5'd18: r = 40'sd64;
      5'd19: r = 40'sd32;
      5'd20: r = 40'sd16;
      5'd21: r = 40'sd8;
      5'd22: r = 40'sd4;
      5'd23: r = 40'sd2;
      default: r = 40'sd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/icaf_divider.sv
// Bit-serial unsigned divider: 32-bit magnitude by 16-bit divisor, one quotient bit a cycle.
// Depends on icaf_pkg.
module icaf_divider
  import icaf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o
);

  logic [31:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [16:0] trial;

  assign trial      = {rem_q[15:0], quo_q[31]};
  assign quotient_o = quo_q;
  assign done_o     = busy_q && (cnt_q == 6'd0);

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
      end else begin
        // shift in one dividend bit, subtract when it fits
        if (trial >= {1'b0, divisor_i}) begin
          rem_d = trial - {1'b0, divisor_i};
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = trial;
          quo_d = {quo_q[30:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

endmodule

>>> rtl/core/icaf_cordic.sv
// Iterative vectoring CORDIC atan2, angle kept in Q8.24 radians and output in Q16.16, one micro-rotation a cycle.
// Depends on icaf_pkg for the arctangent table and iteration count.
module icaf_cordic
  import icaf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] y_i,
  input  logic signed [31:0] x_i,
  output logic               done_o,
  output logic signed [31:0] angle_o
);

  // x can grow by the CORDIC gain (~1.65) above 2^32 after negation
  logic signed [35:0] x_q, x_d, y_q, y_d;
  logic signed [39:0] z_q, z_d;
  logic [IterW-1:0]   it_q, it_d;
  logic               busy_q, busy_d, zero_q, zero_d;
  logic signed [35:0] xs, ys;
  logic signed [39:0] zs;

  localparam logic [IterW-1:0] LastIt =
    IterW'((AtanIterations < AtanTableSize) ? AtanIterations : AtanTableSize);

  assign xs     = x_q >>> it_q;
  assign ys     = y_q >>> it_q;
  assign zs     = z_q >>> 8;
  assign done_o = busy_q && (it_q == LastIt);
  assign angle_o = zero_q ? 32'sd0 : zs[31:0];

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    it_d   = it_q;
    busy_d = busy_q;
    zero_d = zero_q;
    if (start_i) begin
      busy_d = 1'b1;
      it_d   = '0;
      zero_d = (x_i == 32'sd0) && (y_i == 32'sd0);
      if (x_i < 0) begin
        // pre-rotate by pi into the right half plane
        x_d = -36'(x_i);
        y_d = -36'(y_i);
        z_d = (y_i >= 0) ? PiQ24 : -PiQ24;
      end else begin
        x_d = 36'(x_i);
        y_d = 36'(y_i);
        z_d = '0;
      end
    end else if (busy_q) begin
      if (it_q == LastIt) begin
        busy_d = 1'b0;
      end else begin
        if (y_q < 0) begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - atan_tab(it_q);
        end else begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + atan_tab(it_q);
        end
        it_d = it_q + IterW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      it_q   <= '0;
    end else begin
      busy_q <= busy_d;
      it_q   <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    zero_q <= zero_d;
  end

endmodule

>>> rtl/core/imu_complementary_angle_filter.sv
// Top level of the IMU complementary angle filter.
// Depends on icaf_pkg, icaf_divider and icaf_cordic.
//
// One sample at a time. A result is valid once all three axes have been integrated, and
// is also blended when the accelerometer magnitude lies inside the window. Each axis passes
// through the bit-serial gyro divide (start, 32 quotient bits, done), then a scaling by the
// sample period; the three axes run in turn through one divider. Blending takes each axis in
// turn through the iterative CORDIC atan2 (start, 16 micro-rotations, done) and multiplies.
// The serial divider and CORDIC are shared by all axes. Roll, pitch and yaw persist in
// registers and reset to zero; results are held in an output register until taken, and
// the next sample is accepted once the result register is free, so a new sample is not
// taken before the last result has been taken.
module imu_complementary_angle_filter
  import icaf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z (bits 31:0 upward)
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // roll_angle, pitch_angle, yaw_angle (bits 31:0 upward)
  output logic [95:0]  m_axis_tdata,
  // blended
  output logic         m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [32:0]  cfg_data_i
);

  // configuration
  logic [15:0] sens_q, per_q;
  logic [16:0] gw_q, aw_q;
  logic [32:0] mlo_q, mhi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q <= 16'd131;
      per_q  <= 16'd655;
      gw_q   <= 17'd64225;
      aw_q   <= 17'd1311;
      mlo_q  <= 33'd1411510;
      mhi_q  <= 33'd4705028;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgGyroSens:    sens_q <= cfg_data_i[15:0];
        CfgSamplePer:   per_q  <= cfg_data_i[15:0];
        CfgGyroWeight:  gw_q   <= cfg_data_i[16:0];
        CfgAccelWeight: aw_q   <= cfg_data_i[16:0];
        CfgMagLow:      mlo_q  <= cfg_data_i;
        CfgMagHigh:     mhi_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;
  logic [1:0] ax_q, ax_d;        // axis being processed: 0 pitch, 1 roll, 2 yaw
  logic [1:0] ph_q, ph_d;        // sub-step inside a state
  logic signed [31:0] smp_q [6]; // gx gy gz ax ay az
  logic [31:0] ang_q [3];        // pitch roll yaw
  logic        bl_q, out_v_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] tmp_q;

  // divider
  logic        div_start, div_done;
  logic [31:0] div_quo;
  logic signed [31:0] g_sel;
  logic [31:0] g_mag;
  logic [15:0] divisor;

  always_comb begin
    unique case (ax_q)
      2'd0:    g_sel = smp_q[0];
      2'd1:    g_sel = smp_q[1];
      default: g_sel = smp_q[2];
    endcase
  end
  assign g_mag   = g_sel[31] ? (32'd0 - g_sel) : g_sel;
  assign divisor = (sens_q == 16'd0) ? 16'd1 : sens_q;

  icaf_divider u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(g_mag), .divisor_i(divisor),
    .done_o(div_done), .quotient_o(div_quo)
  );

  // cordic operand pairs: pitch (ay,az), roll (ax,az), yaw (ax,ay)
  logic cor_start, cor_done;
  logic signed [31:0] cy, cx, cor_ang;
  always_comb begin
    unique case (ax_q)
      2'd0:    begin cy = smp_q[4]; cx = smp_q[5]; end
      2'd1:    begin cy = smp_q[3]; cx = smp_q[5]; end
      default: begin cy = smp_q[3]; cx = smp_q[4]; end
    endcase
  end

  icaf_cordic u_cor (
    .clk_i, .rst_ni,
    .start_i(cor_start), .y_i(cy), .x_i(cx),
    .done_o(cor_done), .angle_o(cor_ang)
  );

  logic accept;
  assign s_axis_tready = (state_q == StIdle) && !out_v_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // magnitude of an input word, exact
  function automatic logic [32:0] mag33(input logic signed [31:0] v);
    return v[31] ? (33'd0 - {v[31], v}) : {1'b0, v};
  endfunction

  logic [33:0] in_sum;
  assign in_sum = 34'(mag33(s_axis_tdata[127:96])) + 34'(mag33(s_axis_tdata[159:128]))
                + 34'(mag33(s_axis_tdata[191:160]));

  // next state
  always_comb begin
    state_d = state_q;
    ax_d    = ax_q;
    ph_d    = ph_q;
    unique case (state_q)
      StIdle: if (accept) begin
        state_d = StDiv; ax_d = 2'd0; ph_d = 2'd0;
      end
      StDiv: begin
        if (ph_q == 2'd0) ph_d = 2'd1;
        else if (div_done) begin state_d = StInteg; ph_d = 2'd0; end
      end
      StInteg: begin
        if (ph_q == 2'd0) ph_d = 2'd1;
        else if (ax_q == 2'd2) begin
          ax_d = 2'd0; ph_d = 2'd0;
          state_d = bl_q ? StAtan : StOut;
        end else begin
          ax_d = ax_q + 2'd1; ph_d = 2'd0; state_d = StDiv;
        end
      end
      StAtan: begin
        if (ph_q == 2'd0) ph_d = 2'd1;
        else if (cor_done) begin state_d = StBlend; ph_d = 2'd0; end
      end
      StBlend: begin
        if (ph_q != 2'd3) ph_d = ph_q + 2'd1;
        else if (ax_q == 2'd2) begin state_d = StOut; ph_d = 2'd0; end
        else begin ax_d = ax_q + 2'd1; ph_d = 2'd0; state_d = StAtan; end
      end
      StOut: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // outputs to units
  always_comb begin
    div_start = (state_q == StDiv) && (ph_q == 2'd0);
    cor_start = (state_q == StAtan) && (ph_q == 2'd0);
  end

  // datapath helpers
  logic signed [31:0] quo_s;
  assign quo_s = g_sel[31] ? (32'sd0 - $signed(div_quo)) : $signed(div_quo);

  logic signed [31:0] ang_cur;
  always_comb begin
    unique case (ax_q)
      2'd0:    ang_cur = ang_q[0];
      2'd1:    ang_cur = ang_q[1];
      default: ang_cur = ang_q[2];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ax_q    <= '0;
      ph_q    <= '0;
      out_v_q <= 1'b0;
      bl_q    <= 1'b0;
      ang_q[0] <= '0; ang_q[1] <= '0; ang_q[2] <= '0;
    end else begin
      state_q <= state_d;
      ax_q    <= ax_d;
      ph_q    <= ph_d;
      if (m_axis_tvalid && m_axis_tready) out_v_q <= 1'b0;
      if (state_q == StOut) out_v_q <= 1'b1;
      if (accept) bl_q <= (in_sum > 34'(mlo_q)) && (in_sum < 34'(mhi_q));
      if (state_q == StInteg && ph_q == 2'd1) begin
        // add the rate times period; roll subtracts
        if (ax_q == 2'd1) ang_q[1] <= ang_q[1] - prod_q[47:16];
        else if (ax_q == 2'd0) ang_q[0] <= ang_q[0] + prod_q[47:16];
        else ang_q[2] <= ang_q[2] + prod_q[47:16];
      end
      if (state_q == StBlend && ph_q == 2'd3) begin
        ang_q[ax_q] <= tmp_q + prod_q[47:16];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < 6; i++) smp_q[i] <= s_axis_tdata[32*i +: 32];
    end
    if (state_q == StInteg && ph_q == 2'd0)
      prod_q <= quo_s * $signed({16'd0, per_q});
    if (state_q == StAtan && cor_done)
      prod_q <= cor_ang * RatioQ16;
    if (state_q == StBlend) begin
      unique case (ph_q)
        2'd0:    tmp_q  <= prod_q[47:16];  // degrees
        2'd1:    prod_q <= 64'(ang_cur) * $signed({15'd0, gw_q});
        2'd2: begin
          tmp_q  <= prod_q[47:16];
          prod_q <= 64'(tmp_q) * $signed({15'd0, aw_q});
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {ang_q[2], ang_q[0], ang_q[1]};
  assign m_axis_tuser  = bl_q;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for imu_complementary_angle_filter: streams IMU samples in, predicts each
// filtered attitude result in fixed point and checks it. Depends on icaf_pkg and the RTL.
module testbench;
  import icaf_pkg::*;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z (bits 31:0 upward)
  logic [191:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // roll_angle, pitch_angle, yaw_angle (bits 31:0 upward)
  logic [95:0]  m_axis_tdata;
  // blended
  logic         m_axis_tuser;
  logic         cfg_we_i;
  logic [2:0]   cfg_idx_i;
  logic [32:0]  cfg_data_i;

  imu_complementary_angle_filter DUT (.*);

  typedef struct packed {
    logic        blended;
    logic [31:0] yaw;
    logic [31:0] pitch;
    logic [31:0] roll;
  } attitude_t;

  // Predictor copy of the filter state and registers.
  logic [31:0] pitch_q, roll_q, yaw_q;
  logic [15:0] sens_q, period_q;
  logic [16:0] gyro_w_q, accel_w_q;
  logic [32:0] mag_lo_q, mag_hi_q;

  attitude_t attitude_q[$];
  int        mismatches;
  int        stall_hold;   // cycles the receiver must still hold off
  bit        long_gaps;

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint qmul16(longint a, longint b);
    return floor_shift(a * b, 16);
  endfunction

  // Vectoring CORDIC in Q8.24 radians, result in Q16.16.
  function automatic longint atan2_q16(longint y, longint x);
    longint z, xs, ys;
    longint tab;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 52707179 : -52707179;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      case (i)
        0: tab = 13176795;  1: tab = 7778716;  2: tab = 4110060;  3: tab = 2086331;
        4: tab = 1047214;   5: tab = 524117;   6: tab = 262123;   7: tab = 131069;
        default: tab = longint'(1) << (24 - i);
      endcase
      if (y < 0) begin
        x = x - ys; y = y + xs; z = z - tab;
      end else begin
        x = x + ys; y = y - xs; z = z + tab;
      end
    end
    return floor_shift(z, 8);
  endfunction

  function automatic longint integrate_rate(logic signed [31:0] g);
    longint d;
    d = (sens_q == 0) ? 1 : longint'(sens_q);
    return qmul16(longint'(g) / d, longint'(period_q));
  endfunction

  function automatic logic [31:0] blend_angle(logic [31:0] ang, longint acc);
    longint r;
    r = qmul16(longint'(signed'(ang)), longint'(gyro_w_q)) + qmul16(acc, longint'(accel_w_q));
    return r[31:0];
  endfunction

  function automatic longint abs64(logic signed [31:0] v);
    return (v < 0) ? -longint'(v) : longint'(v);
  endfunction

  // Advance the predicted attitude by one sample and queue the expected result.
  task automatic predict_attitude(input logic [191:0] d);
    logic signed [31:0] gx, gy, gz, ax, ay, az;
    longint sum, r;
    attitude_t a;
    {az, ay, ax, gz, gy, gx} = d;
    r = integrate_rate(gx); pitch_q = pitch_q + r[31:0];
    r = integrate_rate(gy); roll_q  = roll_q - r[31:0];
    r = integrate_rate(gz); yaw_q   = yaw_q + r[31:0];
    sum = abs64(ax) + abs64(ay) + abs64(az);
    a.blended = (sum > longint'(mag_lo_q)) && (sum < longint'(mag_hi_q));
    if (a.blended) begin
      pitch_q = blend_angle(pitch_q, qmul16(atan2_q16(ay, az), 3756840));
      roll_q  = blend_angle(roll_q,  qmul16(atan2_q16(ax, az), 3756840));
      yaw_q   = blend_angle(yaw_q,   qmul16(atan2_q16(ax, ay), 3756840));
    end
    a.roll = roll_q; a.pitch = pitch_q; a.yaw = yaw_q;
    attitude_q.push_back(a);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (!long_gaps) return 0;
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 300);
  endfunction

  // Offer one sample and hold it until the transaction completes. Valid drops only
  // for a gap, so back-to-back calls never drive it twice in one step.
  task automatic send_sample(input logic [191:0] d);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_attitude(d);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (attitude_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Write one register; block must be idle.
  task automatic write_reg(input cfg_idx_e idx, input logic [32:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CfgGyroSens:    sens_q    = val[15:0];
      CfgSamplePer:   period_q  = val[15:0];
      CfgGyroWeight:  gyro_w_q  = val[16:0];
      CfgAccelWeight: accel_w_q = val[16:0];
      CfgMagLow:      mag_lo_q  = val;
      CfgMagHigh:     mag_hi_q  = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Random accel component between -2 g and +2 g on a Q16.16 scale, sometimes zero or anything.
  function automatic logic [31:0] rand_accel();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'h0;
      default: return 32'($urandom_range(0, 2 * 65536 * 2)) - 32'(65536 * 2);
    endcase
  endfunction

  function automatic logic [191:0] rand_sample();
    logic [31:0] g[3];
    foreach (g[i]) g[i] = ($urandom_range(0, 3) == 0) ? $urandom()
                                                     : 32'($urandom_range(0, 1 << 24)) - (1 << 23);
    return {rand_accel(), rand_accel(), rand_accel(), g[2], g[1], g[0]};
  endfunction

  task automatic test_directed();
    logic [31:0] ext[6];
    ext = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h00010000, 32'h00000001};
    // Zero operands, extremes of every field, and accelerometer samples outside the default window.
    send_sample('0);
    foreach (ext[i]) send_sample({6{ext[i]}});
    send_sample({32'h0, 32'h0, 32'h0, 32'h7fffffff, 32'h80000000, 32'h00830000});
    send_sample({32'h00010000, 32'h0, 32'h0, 96'h0});
    send_sample({32'h00010000, 32'hffff0000, 32'h00001000, 96'h0});
    send_sample({32'hffff0000, 32'h00004000, 32'hffffc000, 96'h0});
    send_sample({32'hffff0000, 32'h0, 32'hffffc000, 96'h0});
    send_sample({32'h0, 32'hffff0000, 32'h00010000, 96'h0});
    send_sample({32'h0, 32'hffff0000, 32'hffff0000, 96'h0});
    for (int i = 0; i < 8; i++) send_sample(rand_sample());
    drain_results();
  endtask

  task automatic test_random(input int n);
    long_gaps = 1'b1;
    for (int i = 0; i < n; i++) send_sample(rand_sample());
    drain_results();
  endtask

  // Receiver holds off while the sender offers samples; then sender waits for all results.
  task automatic test_backpressure();
    @(negedge clk_i);
    stall_hold = 400;
    @(posedge clk_i);
    for (int i = 0; i < 6; i++) send_sample(rand_sample());
    drain_results();
    send_sample(rand_sample());
    drain_results();
  endtask

  // Extremes and odd settings: zero divisor, weights above one, empty window.
  task automatic test_settings();
    write_reg(CfgGyroSens, 33'd0);
    write_reg(CfgSamplePer, 33'd65535);
    write_reg(CfgGyroWeight, 33'h1ffff);
    write_reg(CfgAccelWeight, 33'h1ffff);
    write_reg(CfgMagLow, 33'd0);
    write_reg(CfgMagHigh, 33'h1ffffffff);
    test_random(120);
    write_reg(CfgGyroSens, 33'd65535);
    write_reg(CfgSamplePer, 33'd0);
    write_reg(CfgGyroWeight, 33'd0);
    write_reg(CfgAccelWeight, 33'd65536);
    write_reg(CfgMagLow, 33'h1ffffffff);
    write_reg(CfgMagHigh, 33'd0);
    test_random(60);
    write_reg(CfgGyroSens, 33'd1);
    write_reg(CfgSamplePer, 33'd1000);
    write_reg(CfgGyroWeight, 33'd65536);
    write_reg(CfgAccelWeight, 33'd0);
    write_reg(CfgMagLow, 33'd65536);
    write_reg(CfgMagHigh, 33'd600000);
    test_random(120);
    write_reg(CfgGyroSens, 33'd131);
    write_reg(CfgSamplePer, 33'd655);
    write_reg(CfgGyroWeight, 33'd64225);
    write_reg(CfgAccelWeight, 33'd1311);
    write_reg(CfgMagLow, 33'd1411510);
    write_reg(CfgMagHigh, 33'd4705028);
  endtask

  // Receiver side: a counted long hold-off on request; otherwise always ready, or with long gaps
  // on, random ready and occasional long hold-offs.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_hold > 0) begin
      stall_hold    <= stall_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (!long_gaps) begin
      m_axis_tready <= 1'b1;
    end else if ($urandom_range(0, 199) == 0) begin
      stall_hold    <= $urandom_range(10, 150);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) < 80);
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    attitude_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata};
      if (attitude_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = attitude_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: roll %h/%h pitch %h/%h yaw %h/%h blended %b/%b (exp/act)",
                     want.roll, got.roll, want.pitch, got.pitch, want.yaw, got.yaw,
                     want.blended, got.blended);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        idle = 0;
      else idle++;
      if (idle >= 20000) begin
        $display("imu_complementary_angle_filter test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgGyroSens;
    cfg_data_i = '0;
    stall_hold = 0;
    long_gaps = 1'b0;
    mismatches = 0;
    pitch_q = '0; roll_q = '0; yaw_q = '0;
    sens_q = 16'd131; period_q = 16'd655;
    gyro_w_q = 17'd64225; accel_w_q = 17'd1311;
    mag_lo_q = 33'd1411510; mag_hi_q = 33'd4705028;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(250);
    test_backpressure();
    test_settings();
    test_random(170);
    drain_results();
    if (mismatches == 0 && attitude_q.size() == 0) begin
      $display("imu_complementary_angle_filter test passed");
    end else begin
      $display("imu_complementary_angle_filter test failed");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/core/icaf_pkg.sv
rtl/core/icaf_divider.sv
rtl/core/icaf_cordic.sv
rtl/core/imu_complementary_angle_filter.sv
sim/testbench.sv
